// ----- rtl/bm16_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bm16_pkg;

  // fixed widths of the operand and product ports
  localparam int IN_WIDTH  = 16;
  localparam int OUT_WIDTH = 32;

  // booth recoding of the pair {multiplier lsb, extra bit}
  localparam logic [1:0] BOOTH_ADD = 2'b01;
  localparam logic [1:0] BOOTH_SUB = 2'b10;

  // control carried along the chain with each transaction
  typedef struct packed {
    logic valid;
  } bm16_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/booth_multiplier_16bit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+---------------------------
// operands | in        | start high while busy low  | multiplicand, multiplier
// product  | out       | done high for one cycle    | product
//
// one booth step per cell, OPERAND_WIDTH cells in a row; a transaction
// accepted on start shows its product on done once it has passed through
// every registered cell of the chain
// a new transaction may enter at every edge, so busy stays low
// synchronous active-high reset clears the valid bits of the chain only
// the receiver cannot stall: each product is shown for one cycle only
module booth_multiplier_16bit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  output logic                              busy,
  input  wire  signed [bm16_pkg::IN_WIDTH-1:0]  multiplicand,
  input  wire  signed [bm16_pkg::IN_WIDTH-1:0]  multiplier,
  output logic                              done,
  output logic signed [bm16_pkg::OUT_WIDTH-1:0] product
);
  import bm16_pkg::*;

  localparam int W = OPERAND_WIDTH;

  // chain taps: index 0 feeds the first cell, index W is the last cell's output
  bm16_ctrl_t   ctrl [0:W];
  logic [W-1:0] md   [0:W];
  logic [W-1:0] ac   [0:W];
  logic [W-1:0] mq   [0:W];
  logic         q1   [0:W];
  logic [2*W-1:0] full;

  // never held off: the chain takes a transaction every cycle
  assign busy = 1'b0;

  // operands are sign extended from the port width to W bits, or cut to their low W bits when W is not wider
  generate
    if (W <= IN_WIDTH) begin : g_in_narrow
      assign md[0] = multiplicand[W-1:0];
      assign mq[0] = multiplier[W-1:0];
    end else begin : g_in_wide
      assign md[0] = {{(W-IN_WIDTH){multiplicand[IN_WIDTH-1]}}, multiplicand};
      assign mq[0] = {{(W-IN_WIDTH){multiplier[IN_WIDTH-1]}}, multiplier};
    end
  endgenerate

  // accumulator and extra bit start at zero
  assign ctrl[0].valid = start & ~busy;
  assign ac[0]         = '0;
  assign q1[0]         = 1'b0;

  generate
    for (genvar i = 0; i < W; i++) begin : g_cell
      bm16_cell #(
        .W(W)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .in_ctrl  (ctrl[i]),
        .in_md    (md[i]),
        .in_ac    (ac[i]),
        .in_mq    (mq[i]),
        .in_q1    (q1[i]),
        .out_ctrl (ctrl[i+1]),
        .out_md   (md[i+1]),
        .out_ac   (ac[i+1]),
        .out_mq   (mq[i+1]),
        .out_q1   (q1[i+1])
      );
    end
  endgenerate

  // product is ac:mq, kept to the low 32 bits or zero extended
  assign full = {ac[W], mq[W]};

  generate
    if (2 * W >= OUT_WIDTH) begin : g_out_wide
      assign product = full[OUT_WIDTH-1:0];
    end else begin : g_out_narrow
      assign product = {{(OUT_WIDTH-2*W){1'b0}}, full};
    end
  endgenerate

  // the last cell's valid bit is the done strobe
  assign done = ctrl[W].valid;

  // every accepted transaction comes out on done once it has passed every cell
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##W done)
    else $error("product missing W cycles after start");

  // no product without a matching accepted transaction entering the chain before it
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, W))
    else $error("product without a matching start");

  // a zero multiplicand always yields a zero product
  a_zero_md : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && multiplicand == '0) |-> ##W (product == '0))
    else $error("nonzero product for zero multiplicand");

  // the copies leaving the last cell belong to the transaction on done
  a_chain_copy : assert property (@(posedge clk) disable iff (rst)
    done |-> (md[W] == $past(md[0], W)) && (q1[W] == $past(mq[0][W-1], W)))
    else $error("chain copies out of step with the product");

endmodule

`default_nettype wire

// ----- rtl/bm16_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bm16_cell #(
  parameter int W = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  bm16_pkg::bm16_ctrl_t in_ctrl,
  input  wire  [W-1:0]        in_md,
  input  wire  [W-1:0]        in_ac,
  input  wire  [W-1:0]        in_mq,
  input  wire                 in_q1,
  output bm16_pkg::bm16_ctrl_t out_ctrl,
  output logic [W-1:0]        out_md,
  output logic [W-1:0]        out_ac,
  output logic [W-1:0]        out_mq,
  output logic                out_q1
);
  import bm16_pkg::*;

  logic [W-1:0] ac_sum;
  logic [W-1:0] ac_next;
  logic [W-1:0] mq_next;

  // add or subtract the multiplicand or hold ac, wrapping at W bits
  always_comb begin
    case ({in_mq[0], in_q1})
      BOOTH_ADD: ac_sum = in_ac + in_md;
      BOOTH_SUB: ac_sum = in_ac - in_md;
      default:   ac_sum = in_ac;
    endcase
  end

  // arithmetic shift right of ac:mq:q1 as one register
  assign ac_next = {ac_sum[W-1], ac_sum[W-1:1]};
  assign mq_next = {ac_sum[0], in_mq[W-1:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl.valid <= 1'b0;
    end else begin
      out_ctrl.valid <= in_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_md <= in_md;
    out_ac <= ac_next;
    out_mq <= mq_next;
    out_q1 <= in_mq[0];
  end

endmodule

`default_nettype wire

// ----- tb/sv/booth_multiplier_16bit_test.sv -----
`timescale 1ns / 1ps

// self-checking bench for the 16-bit radix-2 booth multiplier
// each transaction accepted on start/busy is run through a local booth model
// and the expected product is queued; every done strobe pops the oldest one
module booth_multiplier_16bit_test;
  import bm16_pkg::*;

  // depth of the cell chain in the block under test, used to size the drain and the final watch
  localparam int PRODUCT_LATENCY = 16;
  localparam int DRAIN_LIMIT     = 4 * PRODUCT_LATENCY + 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [IN_WIDTH-1:0] multiplicand = '0;
  logic signed [IN_WIDTH-1:0] multiplier = '0;
  wire busy;
  wire done;
  wire signed [OUT_WIDTH-1:0] product;

  // products still owed by the block, oldest first
  logic [OUT_WIDTH-1:0] expected_products[$];
  logic [OUT_WIDTH-1:0] oldest_product;
  int fail_count = 0;
  // sender inserts random idle cycles only while this is set
  bit allow_gaps = 1'b1;

  booth_multiplier_16bit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .multiplicand(multiplicand),
    .multiplier(multiplier),
    .done(done),
    .product(product)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // safety net in case a handshake never completes
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // booth steps over {accumulator, multiplier register, extra bit}
  // add and subtract wrap at the operand width, then the whole register
  // shifts right arithmetically; the answer is accumulator:multiplier
  function automatic logic [OUT_WIDTH-1:0] booth_product(input logic [IN_WIDTH-1:0] md,
                                                         input logic [IN_WIDTH-1:0] mq);
    logic [IN_WIDTH-1:0] acc;
    logic [IN_WIDTH-1:0] mplr;
    logic                q_ext;
    acc   = '0;
    mplr  = mq;
    q_ext = 1'b0;
    for (int i = 0; i < IN_WIDTH; i++) begin
      case ({mplr[0], q_ext})
        BOOTH_ADD: acc = acc + md;
        BOOTH_SUB: acc = acc - md;
        default: ;
      endcase
      {acc, mplr, q_ext} = {acc[IN_WIDTH-1], acc, mplr};
    end
    return {acc, mplr};
  endfunction

  // operand mix: half full-range values, plus small numbers, values near
  // the extremes and runs of ones that make booth add and subtract often
  function automatic logic [IN_WIDTH-1:0] random_operand();
    logic [IN_WIDTH-1:0] lo_mask;
    logic [IN_WIDTH-1:0] hi_mask;
    logic [IN_WIDTH-1:0] val;
    int unsigned sel;
    sel     = $urandom_range(0, 99);
    lo_mask = {IN_WIDTH{1'b1}} << $urandom_range(0, IN_WIDTH - 1);
    hi_mask = {IN_WIDTH{1'b1}} << $urandom_range(0, IN_WIDTH - 1);
    if (sel < 50) begin
      val = IN_WIDTH'($urandom);
    end else if (sel < 70) begin
      val = IN_WIDTH'($urandom_range(0, 16));
      val = val - 16'd8;
    end else if (sel < 85) begin
      val = IN_WIDTH'($urandom_range(0, 7));
      val = $urandom_range(0, 1) ? 16'h8000 + val : 16'h7FFF - val;
    end else begin
      val = lo_mask ^ hi_mask;
      if ($urandom_range(0, 1)) val = ~val;
    end
    return val;
  endfunction

  // one transaction on the operand channel; start stays high on return so
  // a following call can keep the channel full without a dead cycle
  task automatic send_operands(input logic [IN_WIDTH-1:0] md, input logic [IN_WIDTH-1:0] mq);
    bit taken;
    while (allow_gaps && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    multiplicand <= md;
    multiplier   <= mq;
    // busy is looked at mid-cycle so the accept decision never races the edge
    do begin
      @(negedge clk);
      taken = (busy === 1'b0);
      @(posedge clk);
    end while (!taken);
    expected_products.push_back(booth_product(md, mq));
  endtask

  // pause the sender until every owed product has come back
  task automatic wait_until_drained();
    start <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
  endtask

  // product checker, sampled mid-cycle; the receiver never stalls
  always @(negedge clk) begin
    if (!rst) begin
      if ($isunknown(done)) begin
        $error("done: expected a known value, actual %b", done);
        fail_count++;
      end else if (done) begin
        if (expected_products.size() == 0) begin
          $error("product: expected no transaction, actual %0d (%h)", product, product);
          fail_count++;
        end else begin
          oldest_product = expected_products.pop_front();
          if (product !== oldest_product) begin
            $error("product: expected %0d (%h), actual %0d (%h)",
                   $signed(oldest_product), oldest_product, product, product);
            fail_count++;
          end
        end
      end
    end
  end

  // every pairing of the field extremes, most negative multiplicand included
  task automatic test_corner_operands();
    logic [IN_WIDTH-1:0] corners[5];
    corners = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
    foreach (corners[i]) begin
      foreach (corners[j]) begin
        send_operands(corners[i], corners[j]);
      end
    end
  endtask

  // multiplicand of -32768 can overflow the accumulator, wrapped result stands
  task automatic test_most_negative_multiplicand();
    repeat (20) send_operands(16'h8000, random_operand());
  endtask

  // long stretch with a transaction on every cycle
  task automatic test_back_to_back();
    allow_gaps = 1'b0;
    repeat (150) send_operands(random_operand(), random_operand());
    allow_gaps = 1'b1;
  endtask

  // short bursts, each followed by a full drain of the chain
  task automatic test_pause_until_drained();
    repeat (4) begin
      repeat (10) send_operands(random_operand(), random_operand());
      wait_until_drained();
    end
  endtask

  // random operands with random idle cycles on the sender
  task automatic test_random_with_gaps();
    repeat (180) send_operands(random_operand(), random_operand());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_corner_operands();
    test_most_negative_multiplicand();
    test_back_to_back();
    test_pause_until_drained();
    test_random_with_gaps();

    // let the chain empty, then watch a little longer for stray strobes
    start <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && expected_products.size() != 0; n++) @(posedge clk);
    repeat (PRODUCT_LATENCY + 4) @(posedge clk);

    if (expected_products.size() != 0) begin
      $error("product: expected %0d more transactions, actual none", expected_products.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- booth_multiplier_16bit.f -----
rtl/bm16_pkg.sv
rtl/bm16_cell.sv
rtl/booth_multiplier_16bit.sv
tb/sv/booth_multiplier_16bit_test.sv
